/* rtl/slcf_pkg.sv */
`timescale 1ns / 1ps

package slcf_pkg;

  // CRC-16/CCITT-FALSE constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SYNC_FIRST     = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND    = 2'd1;
  localparam logic [1:0] REG_FRAME_VERSION  = 2'd2;
  localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd3;

  // Queue between front and back end.
  localparam int QDEPTH = 2;
  localparam int QCNT_W = 2;

  // Configuration registers as seen by front and back end.
  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] frame_version;
    logic [7:0] payload_length;
  } slcf_cfg_t;

  // One classified payload byte waiting for the back end.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       start;
    logic       finish;
  } slcf_entry_t;

  // Feed one byte into the CRC, most significant bit first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/slcf_front.sv */
`timescale 1ns / 1ps

module slcf_front (
  input  logic                  clk,
  input  logic                  rst,
  input  slcf_pkg::slcf_cfg_t   cfg,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_byte,
  output slcf_pkg::slcf_entry_t entry,
  output logic [7:0]            position
);
  import slcf_pkg::*;

  logic [7:0] position_next;
  logic [7:0] pos_inc;
  logic [7:0] limit;

  // A length of zero closes the frame after one byte.
  assign limit   = (cfg.payload_length == 8'd0) ? 8'd1 : cfg.payload_length;
  assign pos_inc = position + 8'd1;

  // Classify the byte: first of a frame, last of a frame, or neither.
  always_comb begin
    entry.payload_byte = in_byte;
    entry.start        = (position == 8'd0);
    entry.finish       = (pos_inc >= limit);
    position_next      = entry.finish ? 8'd0 : pos_inc;
  end

  // Count payload bytes of the current frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= 8'd0;
    end else if (in_valid && in_ready) begin
      position <= position_next;
    end
  end

endmodule

/* rtl/slcf_queue.sv */
`timescale 1ns / 1ps

module slcf_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push_valid,
  output logic                        push_ready,
  input  slcf_pkg::slcf_entry_t       push_entry,
  output logic                        pop_valid,
  input  logic                        pop_ready,
  output slcf_pkg::slcf_entry_t       pop_entry,
  output logic [slcf_pkg::QCNT_W-1:0] count
);
  import slcf_pkg::*;

  slcf_entry_t slots [QDEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/slcf_back.sv */
`timescale 1ns / 1ps

module slcf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  slcf_pkg::slcf_cfg_t   cfg,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  slcf_pkg::slcf_entry_t q_entry,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last
);
  import slcf_pkg::*;

  localparam logic [2:0] PH_NEW   = 3'd0;
  localparam logic [2:0] PH_SYNC1 = 3'd1;
  localparam logic [2:0] PH_SYNC2 = 3'd2;
  localparam logic [2:0] PH_VER   = 3'd3;
  localparam logic [2:0] PH_LEN   = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_CRCH  = 3'd6;
  localparam logic [2:0] PH_CRCL  = 3'd7;

  logic [2:0]  phase;
  logic [2:0]  phase_next;
  logic [2:0]  cur;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [7:0]  sel_byte;
  logic        sel_last;
  logic        feed;
  logic        load;

  // A new item may enter the output register when it is empty or being taken.
  assign load = q_valid && (!out_valid || out_ready);

  // A fresh entry starts with the header only when it opens a frame.
  always_comb begin
    if (phase == PH_NEW) begin
      cur = q_entry.start ? PH_SYNC1 : PH_DATA;
    end else begin
      cur = phase;
    end
  end

  // Byte sequencer: one output item per step.
  always_comb begin
    sel_byte   = q_entry.payload_byte;
    sel_last   = 1'b0;
    feed       = 1'b0;
    q_ready    = 1'b0;
    phase_next = phase;
    unique case (cur)
      PH_SYNC1: begin
        sel_byte   = cfg.sync_first;
        phase_next = PH_SYNC2;
      end
      PH_SYNC2: begin
        sel_byte   = cfg.sync_second;
        phase_next = PH_VER;
      end
      PH_VER: begin
        sel_byte   = cfg.frame_version;
        feed       = 1'b1;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        sel_byte   = cfg.payload_length;
        feed       = 1'b1;
        phase_next = PH_DATA;
      end
      PH_CRCH: begin
        sel_byte   = crc[15:8];
        phase_next = PH_CRCL;
      end
      PH_CRCL: begin
        sel_byte   = crc[7:0];
        sel_last   = 1'b1;
        q_ready    = load;
        phase_next = PH_NEW;
      end
      default: begin
        // Payload byte; the trailer follows when it closes the frame.
        feed    = 1'b1;
        q_ready = load && !q_entry.finish;
        phase_next = q_entry.finish ? PH_CRCH : PH_NEW;
      end
    endcase
  end

  // Running CRC, restored to its initial value after each trailer.
  always_comb begin
    if (cur == PH_CRCL) begin
      crc_next = CRC_INIT;
    end else if (feed) begin
      crc_next = crc_feed(crc, sel_byte);
    end else begin
      crc_next = crc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NEW;
      crc   <= CRC_INIT;
    end else if (load) begin
      phase <= phase_next;
      crc   <= crc_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      out_last <= sel_last;
    end
  end

endmodule

/* rtl/sync_length_crc16_framer_top.sv */
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Contents
// cfg      in   psel/penable       APB registers: sync_first, sync_second,
//                                  frame_version, payload_length at 0x0..0xC
// s_axis   in   s_tvalid/s_tready  one payload byte per item
// m_axis   out  m_tvalid/m_tready  one framed byte per item, tlast on CRC low byte
//
// The back-end byte sequencer sets the rate: each payload item yields its byte
// after the sync, version and length bytes if it opens a frame and before the
// CRC bytes if it closes one. A payload byte is held in the queue, then in the
// output register. Reset clears the queue, frame position, CRC and registers.
// The two-entry queue lets input be taken while the output side stalls.

module sync_length_crc16_framer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] payload_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] frame_byte
  output logic        m_tlast
);
  import slcf_pkg::*;

  slcf_cfg_t         cfg;
  slcf_entry_t       front_entry;
  slcf_entry_t       q_entry;
  logic              q_valid;
  logic              q_ready;
  logic [QCNT_W-1:0] q_count;
  logic [7:0]        position;
  logic              cfg_wr;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first     <= 8'd0;
      cfg.sync_second    <= 8'd0;
      cfg.frame_version  <= 8'd0;
      cfg.payload_length <= 8'd1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SYNC_FIRST:     cfg.sync_first     <= pwdata[7:0];
        REG_SYNC_SECOND:    cfg.sync_second    <= pwdata[7:0];
        REG_FRAME_VERSION:  cfg.frame_version  <= pwdata[7:0];
        default:            cfg.payload_length <= pwdata[7:0];
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_SYNC_FIRST:     prdata = {24'd0, cfg.sync_first};
      REG_SYNC_SECOND:    prdata = {24'd0, cfg.sync_second};
      REG_FRAME_VERSION:  prdata = {24'd0, cfg.frame_version};
      default:            prdata = {24'd0, cfg.payload_length};
    endcase
  end

  slcf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .entry    (front_entry),
    .position (position)
  );

  slcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (s_tready),
    .push_entry (front_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_entry  (q_entry),
    .count      (q_count)
  );

  slcf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

  // The queue never holds more than its depth.
  assert property (@(posedge clk) disable iff (rst) q_count <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  // Input is refused only while the queue is full.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (q_count == QCNT_W'(QDEPTH)))
    else $error("input stalled with room in queue");

  // The frame position always wraps before reaching its top value.
  assert property (@(posedge clk) disable iff (rst) position != 8'hFF)
    else $error("frame position overran");

  // An item accepted into an empty queue is held there at the next edge.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && q_count == '0 && !m_tvalid) |=> (q_count != '0))
    else $error("accepted item lost before queue");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import slcf_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_CAP    = 40;

  // One byte of the framed output stream with its end-of-frame flag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } framed_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] payload_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] frame_byte
  logic        m_tlast;

  // Shadow of the registers and of the framer state.
  slcf_cfg_t    shadow_cfg;
  logic [15:0]  frame_crc;
  logic [7:0]   frame_pos;
  framed_byte_t framed_due[$];

  int  errors = 0;
  int  cycle_count = 0;
  int  payload_sent = 0;
  int  bytes_checked = 0;
  int  frames_closed = 0;
  int  cfg_writes = 0;
  bit  tx_gaps = 1'b1;
  bit  quiet = 1'b0;
  int  hold_reqs = 0;

  sync_length_crc16_framer_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes still due", $time, framed_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // CRC-16/CCITT-FALSE update for one byte, most significant bit first.
  function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    repeat (8) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic last);
    framed_byte_t fb;
    fb.data = b;
    fb.last = last;
    framed_due.push_back(fb);
  endfunction

  // Works out the framed bytes that one accepted payload byte causes.
  function automatic void frame_payload(input logic [7:0] b);
    logic [7:0] close_at;
    if (frame_pos == 8'd0) begin
      frame_crc = CRC_INIT;
      queue_byte(shadow_cfg.sync_first, 1'b0);
      queue_byte(shadow_cfg.sync_second, 1'b0);
      queue_byte(shadow_cfg.frame_version, 1'b0);
      frame_crc = crc_ccitt_byte(frame_crc, shadow_cfg.frame_version);
      queue_byte(shadow_cfg.payload_length, 1'b0);
      frame_crc = crc_ccitt_byte(frame_crc, shadow_cfg.payload_length);
    end
    queue_byte(b, 1'b0);
    frame_crc = crc_ccitt_byte(frame_crc, b);
    frame_pos = frame_pos + 8'd1;
    // A length of zero still closes the frame after one byte.
    close_at = (shadow_cfg.payload_length == 8'd0) ? 8'd1 : shadow_cfg.payload_length;
    if (frame_pos >= close_at) begin
      queue_byte(frame_crc[15:8], 1'b0);
      queue_byte(frame_crc[7:0], 1'b1);
      frame_crc = CRC_INIT;
      frame_pos = 8'd0;
    end
  endfunction

  // Compare each output item with the oldest expected byte.
  always @(posedge clk) begin
    framed_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (framed_due.size() == 0) begin
        errors++;
        if (errors < REPORT_CAP) begin
          $display("%0t: unexpected output: expected none, actual 0x%02h last %0b",
                   $time, m_tdata, m_tlast);
        end
      end else begin
        want = framed_due.pop_front();
        bytes_checked++;
        if (m_tlast) frames_closed++;
        if (m_tdata !== want.data) begin
          errors++;
          if (errors < REPORT_CAP) begin
            $display("%0t: frame_byte mismatch: expected 0x%02h, actual 0x%02h",
                     $time, want.data, m_tdata);
          end
        end
        if (m_tlast !== want.last) begin
          errors++;
          if (errors < REPORT_CAP) begin
            $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                     $time, want.last, m_tlast);
          end
        end
      end
    end
  end

  // Output side: random stall bursts in segments, plus one long hold on request.
  initial begin : output_side
    int seg_left;
    bit seg_stalls;
    int hold_cnt;
    int holds_done;
    seg_left = 0;
    seg_stalls = 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        m_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        holds_done++;
        m_tready <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 120);
          seg_stalls = ($urandom_range(0, 2) != 0);
        end
        seg_left--;
        if (seg_stalls && !quiet && $urandom_range(0, 6) == 0) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one payload byte and wait until it is taken. Valid stays high afterwards.
  task automatic send_payload(input logic [7:0] b);
    if (tx_gaps && !quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    frame_payload(b);
    payload_sent++;
  endtask

  // Stop offering and wait until every expected byte has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (framed_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
    logic [31:0] noise;
    noise = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {noise[31:8], val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SYNC_FIRST:     shadow_cfg.sync_first = val;
      REG_SYNC_SECOND:    shadow_cfg.sync_second = val;
      REG_FRAME_VERSION:  shadow_cfg.frame_version = val;
      REG_PAYLOAD_LENGTH: shadow_cfg.payload_length = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic write_all(input logic [7:0] s1, input logic [7:0] s2,
                           input logic [7:0] ver, input logic [7:0] len);
    reg_write(REG_SYNC_FIRST, s1);
    reg_write(REG_SYNC_SECOND, s2);
    reg_write(REG_FRAME_VERSION, ver);
    reg_write(REG_PAYLOAD_LENGTH, len);
  endtask

  // Reset values: zero sync and version, one byte per frame.
  task automatic test_default_registers();
    send_payload(8'h00);
    send_payload(8'hFF);
    wait_drained();
  endtask

  // Extreme values in the sync and version registers and in the payload.
  task automatic test_field_extremes();
    write_all(8'hFF, 8'h00, 8'hFF, 8'd2);
    send_payload(8'hFF);
    send_payload(8'h00);
    wait_drained();
    write_all(8'h00, 8'hFF, 8'h00, 8'd1);
    send_payload(8'hA5);
    wait_drained();
  endtask

  // A length of zero is sent as such but closes after one byte.
  task automatic test_zero_length();
    write_all(8'h55, 8'hAA, 8'h5A, 8'd0);
    send_payload(8'h3C);
    send_payload(8'hC3);
    wait_drained();
  endtask

  // Lowering the length below the bytes already passed closes on the next byte.
  task automatic test_length_cut();
    reg_write(REG_PAYLOAD_LENGTH, 8'd6);
    send_payload(8'h11);
    send_payload(8'h22);
    send_payload(8'h33);
    wait_drained();
    reg_write(REG_PAYLOAD_LENGTH, 8'd2);
    send_payload(8'h44);
    send_payload(8'h80);
    send_payload(8'h01);
    wait_drained();
  endtask

  // New sync and version values apply only from the next frame.
  task automatic test_register_change_mid_frame();
    write_all(8'hB5, 8'h62, 8'h01, 8'd4);
    send_payload(8'h7E);
    send_payload(8'h81);
    wait_drained();
    write_all(8'hC3, 8'h3C, 8'hF0, 8'd4);
    send_payload(8'h0F);
    send_payload(8'hF0);
    send_payload(8'h99);
    wait_drained();
  endtask

  // Output held off for a long time while input keeps coming, so the block fills.
  task automatic test_output_backpressure();
    int k;
    write_all(8'hEB, 8'h90, 8'h02, 8'd3);
    tx_gaps = 1'b0;
    hold_reqs++;
    for (k = 0; k < 40; k++) send_payload(8'($urandom_range(0, 255)));
    wait_drained();
    tx_gaps = 1'b1;
  endtask

  // One frame of the largest length.
  task automatic test_longest_frame();
    write_all(8'h7F, 8'h80, 8'hFE, 8'd255);
    do send_payload(8'($urandom_range(0, 255))); while (frame_pos != 8'd0);
    wait_drained();
  endtask

  // Random registers and payload byte counts; often leaves a frame open across a change.
  task automatic test_random_frames(input int target);
    int done;
    int n;
    int k;
    int r;
    logic [7:0] len;
    done = 0;
    while (done < target) begin
      r = $urandom_range(0, 19);
      if (r == 0) len = 8'd0;
      else if (r <= 2) len = 8'($urandom_range(9, 40));
      else len = 8'($urandom_range(1, 6));
      if ($urandom_range(0, 3) != 0) begin
        write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), len);
      end else begin
        reg_write(REG_PAYLOAD_LENGTH, len);
      end
      tx_gaps = ($urandom_range(0, 3) != 0);
      n = $urandom_range(1, 3 * ((len == 8'd0) ? 1 : len) + 2);
      if (n > 60) n = 60;
      for (k = 0; k < n; k++) send_payload(8'($urandom_range(0, 255)));
      done += n;
      wait_drained();
    end
    tx_gaps = 1'b1;
  endtask

  // Final stretch with no idling on either side.
  task automatic test_quiet_tail();
    int k;
    quiet = 1'b1;
    write_all(8'hAA, 8'h55, 8'h10, 8'd4);
    for (k = 0; k < 50; k++) send_payload(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  initial begin
    shadow_cfg.sync_first     = 8'h00;
    shadow_cfg.sync_second    = 8'h00;
    shadow_cfg.frame_version  = 8'h00;
    shadow_cfg.payload_length = 8'd1;
    frame_crc = CRC_INIT;
    frame_pos = 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_registers();
    test_field_extremes();
    test_zero_length();
    test_length_cut();
    test_register_change_mid_frame();
    test_output_backpressure();
    test_longest_frame();
    test_random_frames(120);
    test_quiet_tail();

    $display("Sent %0d payload bytes, checked %0d framed bytes in %0d closed frames.",
             payload_sent, bytes_checked, frames_closed);
    $display("%0d register writes: zero, cut and 255-byte lengths, mid-frame changes, long hold.",
             cfg_writes);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/slcf_pkg.sv
rtl/slcf_front.sv
rtl/slcf_queue.sv
rtl/slcf_back.sv
rtl/sync_length_crc16_framer_top.sv
verif/tb_top.sv
